// ----- rtl/pcig_pkg.sv -----
// package for the pooled convolution index generator
// field widths, configuration register codes, clamp helpers; no dependencies
package pcig_pkg;

  localparam int unsigned IN_COORD_W  = 12;
  localparam int unsigned OUT_COORD_W = 10;
  localparam int unsigned GROUP_W     = 10;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned POOL_RAW_W = 3;
  localparam int unsigned DIM_RAW_W  = 11;

  // sized for the largest pool and output dimension parameters
  localparam int unsigned POOL_W  = 4;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned GCFG_W  = 11;

  localparam int unsigned GROUP_LIMIT = 1024;

  localparam logic [POOL_RAW_W-1:0] POOL_RESET  = 3'd2;
  localparam logic [DIM_RAW_W-1:0]  DIM_RESET   = 11'd1024;
  localparam logic [DIM_RAW_W-1:0]  GROUP_RESET = 11'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_SIZE   = 8'd0,
    REG_OUT_WIDTH   = 8'd1,
    REG_OUT_HEIGHT  = 8'd2,
    REG_CHAN_GROUPS = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [POOL_W-1:0] pool;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [GCFG_W-1:0] groups;
  } pcig_cfg_t;

  typedef struct packed {
    logic [IN_COORD_W-1:0]  in_row;
    logic [IN_COORD_W-1:0]  in_col;
    logic [GROUP_W-1:0]     chan_group;
    logic [OUT_COORD_W-1:0] out_row;
    logic [OUT_COORD_W-1:0] out_col;
    logic                   reset_max;
    logic                   store_output;
  } pcig_idx_t;

  function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_RAW_W-1:0] raw,
                                                   input logic [POOL_W-1:0] lim);
    logic [POOL_W-1:0] v;
    v = POOL_W'(raw);
    if (v == '0) begin
      return POOL_W'(1);
    end
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_RAW_W-1:0] raw,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] v;
    v = DIM_W'(raw);
    if (v == '0) begin
      return DIM_W'(1);
    end
    return (v > lim) ? lim : v;
  endfunction

endpackage

// ----- rtl/pcig_if.sv -----
// channel interfaces: configuration write, request beat, index set beat
// depends on pcig_pkg
interface pcig_cfg_if
  import pcig_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface pcig_req_if;
  logic valid;
  logic ready;
  logic request;

  modport source (output valid, request, input ready);
  modport sink   (input valid, request, output ready);
endinterface

interface pcig_idx_if
  import pcig_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [IN_COORD_W-1:0]  in_row;
  logic [IN_COORD_W-1:0]  in_col;
  logic [GROUP_W-1:0]     chan_group;
  logic [OUT_COORD_W-1:0] out_row;
  logic [OUT_COORD_W-1:0] out_col;
  logic                   reset_max;
  logic                   store_output;

  modport source (output valid, in_row, in_col, chan_group, out_row, out_col,
                  reset_max, store_output, input ready);
  modport sink   (input valid, in_row, in_col, chan_group, out_row, out_col,
                  reset_max, store_output, output ready);
endinterface

// ----- rtl/pcig_cfg.sv -----
// configuration registers, clamped to their legal ranges on write
// depends on pcig_pkg and pcig_cfg_if
module pcig_cfg
  import pcig_pkg::*;
#(
  parameter int unsigned MAX_OUT_DIM = 1024,
  parameter int unsigned MAX_POOL    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pcig_cfg_if.sink          cfg_i,
  output pcig_cfg_t         cfg_o
);

  localparam logic [POOL_W-1:0] PoolLim  = POOL_W'(MAX_POOL);
  localparam logic [DIM_W-1:0]  DimLim   = DIM_W'(MAX_OUT_DIM);
  localparam logic [DIM_W-1:0]  GroupLim = DIM_W'(GROUP_LIMIT);

  pcig_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool   <= clamp_pool(POOL_RESET, PoolLim);
      cfg_q.width  <= clamp_dim(DIM_RESET, DimLim);
      cfg_q.height <= clamp_dim(DIM_RESET, DimLim);
      cfg_q.groups <= GCFG_W'(clamp_dim(GROUP_RESET, GroupLim));
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_POOL_SIZE:   cfg_q.pool   <= clamp_pool(cfg_i.data[POOL_RAW_W-1:0], PoolLim);
        REG_OUT_WIDTH:   cfg_q.width  <= clamp_dim(cfg_i.data[DIM_RAW_W-1:0], DimLim);
        REG_OUT_HEIGHT:  cfg_q.height <= clamp_dim(cfg_i.data[DIM_RAW_W-1:0], DimLim);
        REG_CHAN_GROUPS: cfg_q.groups <= GCFG_W'(clamp_dim(cfg_i.data[DIM_RAW_W-1:0],
                                                           GroupLim));
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pcig_seq.sv -----
// nested window, group and output position counters with index set decode
// depends on pcig_pkg
module pcig_seq
  import pcig_pkg::*;
#(
  parameter int unsigned MAX_OUT_DIM = 1024,
  parameter int unsigned MAX_POOL    = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pcig_cfg_t cfg_i,
  input  logic      advance_i,
  output pcig_idx_t idx_o
);

  localparam int unsigned WIN_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_OUT_DIM);

  logic [WIN_W-1:0]      win_row_q, win_row_d, win_col_q, win_col_d;
  logic [GROUP_W-1:0]    grp_q, grp_d;
  logic [CNT_W-1:0]      orow_q, orow_d, ocol_q, ocol_d;
  logic [IN_COORD_W-1:0] row_base_q, row_base_d, col_base_q, col_base_d;

  logic [POOL_W:0]       col_inc, row_inc;
  logic [GROUP_W:0]      grp_inc;
  logic [DIM_W-1:0]      ocol_inc, orow_inc;
  logic [POOL_W-1:0]     pool_last;

  assign pool_last = cfg_i.pool - POOL_W'(1);

  always_comb begin
    idx_o.in_row       = row_base_q + IN_COORD_W'(win_row_q);
    idx_o.in_col       = col_base_q + IN_COORD_W'(win_col_q);
    idx_o.chan_group   = grp_q;
    idx_o.out_row      = OUT_COORD_W'(orow_q);
    idx_o.out_col      = OUT_COORD_W'(ocol_q);
    idx_o.reset_max    = (win_row_q == '0) && (win_col_q == '0);
    idx_o.store_output = (POOL_W'(win_row_q) == pool_last) &&
                         (POOL_W'(win_col_q) == pool_last);
  end

  always_comb begin
    col_inc  = (POOL_W + 1)'(win_col_q) + (POOL_W + 1)'(1);
    row_inc  = (POOL_W + 1)'(win_row_q) + (POOL_W + 1)'(1);
    grp_inc  = (GROUP_W + 1)'(grp_q) + (GROUP_W + 1)'(1);
    ocol_inc = DIM_W'(ocol_q) + DIM_W'(1);
    orow_inc = DIM_W'(orow_q) + DIM_W'(1);

    win_row_d  = win_row_q;
    win_col_d  = win_col_q;
    grp_d      = grp_q;
    orow_d     = orow_q;
    ocol_d     = ocol_q;
    row_base_d = row_base_q;
    col_base_d = col_base_q;

    if (advance_i) begin
      win_col_d = WIN_W'(col_inc);
      if (col_inc >= (POOL_W + 1)'(cfg_i.pool)) begin
        win_col_d = '0;
        win_row_d = WIN_W'(row_inc);
        if (row_inc >= (POOL_W + 1)'(cfg_i.pool)) begin
          win_row_d = '0;
          grp_d     = GROUP_W'(grp_inc);
          if (grp_inc >= (GROUP_W + 1)'(cfg_i.groups)) begin
            grp_d      = '0;
            col_base_d = col_base_q + IN_COORD_W'(cfg_i.pool);
            ocol_d     = CNT_W'(ocol_inc);
            if (ocol_inc >= cfg_i.width) begin
              ocol_d     = '0;
              col_base_d = '0;
              row_base_d = row_base_q + IN_COORD_W'(cfg_i.pool);
              orow_d     = CNT_W'(orow_inc);
              if (orow_inc >= cfg_i.height) begin
                orow_d     = '0;
                row_base_d = '0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_row_q  <= '0;
      win_col_q  <= '0;
      grp_q      <= '0;
      orow_q     <= '0;
      ocol_q     <= '0;
      row_base_q <= '0;
      col_base_q <= '0;
    end else begin
      win_row_q  <= win_row_d;
      win_col_q  <= win_col_d;
      grp_q      <= grp_d;
      orow_q     <= orow_d;
      ocol_q     <= ocol_d;
      row_base_q <= row_base_d;
      col_base_q <= col_base_d;
    end
  end

`ifndef SYNTH
  a_last_wraps_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && idx_o.store_output |=> (win_row_q == '0) && (win_col_q == '0))
    else $error("window offsets did not wrap after last position");

  a_both_flags_unit_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_o.reset_max && idx_o.store_output |-> cfg_i.pool == POOL_W'(1))
    else $error("first and last window position coincide with pool above one");
`endif

endmodule

// ----- rtl/pooled_conv_index_generator.sv -----
// pooled convolution index generator, top level
// depends on pcig_pkg, pcig_if, pcig_cfg and pcig_seq
//
// Usage:
//   cfg_i  write channel; index selects pool_size (0), out_width (1),
//          out_height (2) or chan_groups (3); other indexes are ignored.
//          Always ready. Write it after reset and before the first request.
//   req_i  request beats; a beat with request high yields one index set,
//          a beat with request low is taken and dropped.
//   idx_o  index set beats in pooling-window order, with reset_max at the
//          first window position and store_output at the last one.
// An index set is registered, valid in the cycle after its request beat.
// Throughput: one index set per cycle while idx_o accepts them, bounded
//   by the single counter update path from position to output registers.
// Reset: all counters clear to zero, registers take their defaults and
//   the output register empties.
// Stall: while the output register holds a beat that idx_o does not take,
//   req_i.ready is low; it rises in the cycle the beat is taken.
module pooled_conv_index_generator
  import pcig_pkg::*;
#(
  parameter int unsigned MAX_OUT_DIM = 1024,
  parameter int unsigned MAX_POOL    = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcig_cfg_if.sink     cfg_i,
  pcig_req_if.sink     req_i,
  pcig_idx_if.source   idx_o
);

  pcig_cfg_t cfg;
  pcig_idx_t idx_next;
  pcig_idx_t data_q;
  logic      valid_q, valid_d;
  logic      advance;

  pcig_cfg #(
    .MAX_OUT_DIM (MAX_OUT_DIM),
    .MAX_POOL    (MAX_POOL)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pcig_seq #(
    .MAX_OUT_DIM (MAX_OUT_DIM),
    .MAX_POOL    (MAX_POOL)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (advance),
    .idx_o     (idx_next)
  );

  assign req_i.ready = !valid_q || idx_o.ready;
  assign advance     = req_i.valid && req_i.ready && req_i.request;

  always_comb begin
    valid_d = valid_q;
    if (advance) begin
      valid_d = 1'b1;
    end else if (idx_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      data_q <= idx_next;
    end
  end

  assign idx_o.valid        = valid_q;
  assign idx_o.in_row       = data_q.in_row;
  assign idx_o.in_col       = data_q.in_col;
  assign idx_o.chan_group   = data_q.chan_group;
  assign idx_o.out_row      = data_q.out_row;
  assign idx_o.out_col      = data_q.out_col;
  assign idx_o.reset_max    = data_q.reset_max;
  assign idx_o.store_output = data_q.store_output;

`ifndef SYNTH
  a_request_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> idx_o.valid)
    else $error("request beat produced no index set");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> idx_o.valid && !idx_o.ready)
    else $error("request side stalled with output free");
`endif

endmodule

// ----- tb/sv/pcig_tb_pkg.sv -----
`timescale 1ns / 100ps
// result tracking for the pooled convolution index generator testbench
// mirrors the register file and window counters; depends on pcig_pkg
package pcig_tb_pkg;
  import pcig_pkg::*;

  localparam int unsigned TB_MAX_OUT_DIM = 1024;
  localparam int unsigned TB_MAX_POOL    = 4;

  class pcig_index_scoreboard;
    logic [POOL_RAW_W-1:0] pool_raw;
    logic [DIM_RAW_W-1:0]  width_raw;
    logic [DIM_RAW_W-1:0]  height_raw;
    logic [DIM_RAW_W-1:0]  groups_raw;

    // kept wide so a counter left past a shrunken limit still wraps
    int unsigned row_base;
    int unsigned col_base;
    int unsigned group_cnt;
    int unsigned out_row_cnt;
    int unsigned out_col_cnt;
    int unsigned win_row;
    int unsigned win_col;

    pcig_idx_t   expected_idx[$];
    int unsigned failures;

    function new();
      pool_raw    = POOL_RESET;
      width_raw   = DIM_RESET;
      height_raw  = DIM_RESET;
      groups_raw  = GROUP_RESET;
      row_base    = 0;
      col_base    = 0;
      group_cnt   = 0;
      out_row_cnt = 0;
      out_col_cnt = 0;
      win_row     = 0;
      win_col     = 0;
      failures    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_POOL_SIZE:   pool_raw   = value[POOL_RAW_W-1:0];
        REG_OUT_WIDTH:   width_raw  = value[DIM_RAW_W-1:0];
        REG_OUT_HEIGHT:  height_raw = value[DIM_RAW_W-1:0];
        REG_CHAN_GROUPS: groups_raw = value[DIM_RAW_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned bounded(int unsigned v, int unsigned hi);
      if (v == 0) begin
        return 1;
      end
      return (v > hi) ? hi : v;
    endfunction

    function pcig_idx_t next_window_index();
      int unsigned p;
      int unsigned w;
      int unsigned h;
      int unsigned g;
      pcig_idx_t   idx;
      p = bounded(pool_raw, TB_MAX_POOL);
      w = bounded(width_raw, TB_MAX_OUT_DIM);
      h = bounded(height_raw, TB_MAX_OUT_DIM);
      g = bounded(groups_raw, GROUP_LIMIT);

      idx.in_row       = IN_COORD_W'(row_base + win_row);
      idx.in_col       = IN_COORD_W'(col_base + win_col);
      idx.chan_group   = GROUP_W'(group_cnt);
      idx.out_row      = OUT_COORD_W'(out_row_cnt);
      idx.out_col      = OUT_COORD_W'(out_col_cnt);
      idx.reset_max    = (win_row == 0) && (win_col == 0);
      idx.store_output = (win_row == p - 1) && (win_col == p - 1);

      win_col++;
      if (win_col >= p) begin
        win_col = 0;
        win_row++;
        if (win_row >= p) begin
          win_row = 0;
          group_cnt++;
          if (group_cnt >= g) begin
            group_cnt = 0;
            col_base  = (col_base + p) & 12'hfff;
            out_col_cnt++;
            if (out_col_cnt >= w) begin
              out_col_cnt = 0;
              col_base    = 0;
              row_base    = (row_base + p) & 12'hfff;
              out_row_cnt++;
              if (out_row_cnt >= h) begin
                out_row_cnt = 0;
                row_base    = 0;
              end
            end
          end
        end
      end
      return idx;
    endfunction

    function void note_request(bit request);
      if (request) begin
        expected_idx.push_back(next_window_index());
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_index(pcig_idx_t got);
      pcig_idx_t want;
      if (expected_idx.size() == 0) begin
        $error("index beat with no request outstanding");
        failures++;
        return;
      end
      want = expected_idx.pop_front();
      compare_field("in_row", want.in_row, got.in_row);
      compare_field("in_col", want.in_col, got.in_col);
      compare_field("chan_group", want.chan_group, got.chan_group);
      compare_field("out_row", want.out_row, got.out_row);
      compare_field("out_col", want.out_col, got.out_col);
      compare_field("reset_max", want.reset_max, got.reset_max);
      compare_field("store_output", want.store_output, got.store_output);
    endfunction

    function int unsigned pending();
      return expected_idx.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/pooled_conv_index_generator_tb.sv -----
`timescale 1ns / 100ps
// top-level testbench for the pooled convolution index generator
// drives config and request beats, checks index beats; depends on pcig_pkg, pcig_tb_pkg
module pooled_conv_index_generator_tb;
  import pcig_pkg::*;
  import pcig_tb_pkg::*;

  localparam int unsigned ITEM_TARGET = 2000;
  localparam int unsigned STALL_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcig_cfg_if cfg_ch ();
  pcig_req_if req_ch ();
  pcig_idx_if idx_ch ();

  pcig_index_scoreboard sb = new();

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned granted;
  int unsigned quiet_cycles = 0;

  pooled_conv_index_generator #(
    .MAX_OUT_DIM(TB_MAX_OUT_DIM),
    .MAX_POOL   (TB_MAX_POOL)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .req_i (req_ch),
    .idx_o (idx_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    idx_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin : index_monitor
    pcig_idx_t got;
    if (rst_ni && idx_ch.valid && idx_ch.ready) begin
      got.in_row       = idx_ch.in_row;
      got.in_col       = idx_ch.in_col;
      got.chan_group   = idx_ch.chan_group;
      got.out_row      = idx_ch.out_row;
      got.out_col      = idx_ch.out_col;
      got.reset_max    = idx_ch.reset_max;
      got.store_output = idx_ch.store_output;
      sb.check_index(got);
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (idx_ch.valid && idx_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_reg(index, value);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] pool,
                           input logic [CFG_DATA_W-1:0] width,
                           input logic [CFG_DATA_W-1:0] height,
                           input logic [CFG_DATA_W-1:0] groups,
                           input bit stray);
    write_reg(REG_POOL_SIZE, pool);
    write_reg(REG_OUT_WIDTH, width);
    write_reg(REG_OUT_HEIGHT, height);
    write_reg(REG_CHAN_GROUPS, groups);
    // unmapped index, must be ignored
    if (stray) begin
      write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom_range(0, 2047)));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_request(input bit request);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.request <= request;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request(request);
    if (request) begin
      granted++;
    end
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return CFG_DATA_W'(0);
      1: return CFG_DATA_W'(1);
      2: return CFG_DATA_W'(1024);
      3: return CFG_DATA_W'(2047);
      4: return CFG_DATA_W'($urandom_range(0, 2047));
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_items;
    int unsigned sent;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    granted        = 0;
    rst_ni         <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.request <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers, one dropped beat in the middle
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    repeat (6) send_request(1'b1);
    wait_for_results();

    // zero sizes behave as one, every beat wraps everything
    configure(0, 0, 1, 1, 1'b0);
    repeat (3) send_request(1'b1);
    wait_for_results();

    // oversized pool and groups clamp to their limits
    configure(7, 2047, 0, 2047, 1'b1);
    repeat (8) send_request(1'b1);
    wait_for_results();

    // window offset now lies past the shrunken pool
    configure(1, 2, 2, 1, 1'b0);
    repeat (3) send_request(1'b1);
    wait_for_results();

    phase = 0;
    while (granted < ITEM_TARGET) begin
      configure(CFG_DATA_W'($urandom_range(0, 7)), pick_dim(), pick_dim(), pick_dim(),
                ($urandom_range(0, 2) == 0));
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 57; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 57; end
        default: begin src_idle_pct = 28; snk_stall_pct = 28; end
      endcase
      phase_items = $urandom_range(100, 200);
      sent = 0;
      while (sent < phase_items) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(1'b0);
        end else begin
          send_request(1'b1);
          sent++;
        end
      end
      wait_for_results();
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      phase++;
    end

    repeat (8) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pcig_pkg.sv
rtl/pcig_if.sv
rtl/pcig_cfg.sv
rtl/pcig_seq.sv
rtl/pooled_conv_index_generator.sv
tb/sv/pcig_tb_pkg.sv
tb/sv/pooled_conv_index_generator_tb.sv
